FILE: src/mwq_pkg.sv
package mwq_pkg;

   localparam int NUM_PRIORITIES = 4;
   localparam int NUM_HANDLES    = 64;
   localparam int PRIO_W         = 2;
   localparam int HANDLE_W       = 6;
   localparam int CMD_W          = 3;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [PRIO_W-1:0]   prio_type;

   // Command codes; codes five to seven are unused and do nothing
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_PUSH   = 3'd1,
      CMD_POP    = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   typedef struct packed {
      handle_type           handle;
      prio_type             prio;
      logic [CMD_W-1:0]     cmd;
   } req_type;

   typedef struct packed {
      logic       any;
      handle_type popped;
      logic       ok;
   } rsp_type;

   // One write port on each link table
   typedef struct packed {
      logic       next_we;
      handle_type next_addr;
      handle_type next_data;
      logic       prev_we;
      handle_type prev_addr;
      handle_type prev_data;
   } link_wr_type;

endpackage

FILE: src/mwq_link_mem.sv
module mwq_link_mem
   import mwq_pkg::*;
(
   input  logic        clock,
   input  logic        rd_en,
   input  handle_type  next_raddr,
   input  handle_type  prev_raddr,
   input  link_wr_type link_wr,
   output handle_type  next_rd,
   output handle_type  prev_rd
);

   handle_type next_mem [NUM_HANDLES];
   handle_type prev_mem [NUM_HANDLES];
   handle_type next_rd_ff;
   handle_type prev_rd_ff;

   // Write the next-link table; read with bypass of a same-edge write, hold on stall
   always_ff @(posedge clock) begin
      if (link_wr.next_we) begin
         next_mem[link_wr.next_addr] <= link_wr.next_data;
      end
      if (rd_en) begin
         if (link_wr.next_we && (link_wr.next_addr == next_raddr)) begin
            next_rd_ff <= link_wr.next_data;
         end else begin
            next_rd_ff <= next_mem[next_raddr];
         end
      end
   end

   // Same for the previous-link table
   always_ff @(posedge clock) begin
      if (link_wr.prev_we) begin
         prev_mem[link_wr.prev_addr] <= link_wr.prev_data;
      end
      if (rd_en) begin
         if (link_wr.prev_we && (link_wr.prev_addr == prev_raddr)) begin
            prev_rd_ff <= link_wr.prev_data;
         end else begin
            prev_rd_ff <= prev_mem[prev_raddr];
         end
      end
   end

   assign next_rd = next_rd_ff;
   assign prev_rd = prev_rd_ff;

endmodule

FILE: src/mwq_list_ctrl.sv
module mwq_list_ctrl
   import mwq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        exec,
   input  req_type     req,
   input  handle_type  next_rd,
   input  handle_type  prev_rd,
   output link_wr_type link_wr,
   output rsp_type     result,
   output handle_type  pop_head_nxt
);

   handle_type              head_ff [NUM_PRIORITIES];
   handle_type              head_in [NUM_PRIORITIES];
   handle_type              tail_ff [NUM_PRIORITIES];
   handle_type              tail_in [NUM_PRIORITIES];
   logic [NUM_HANDLES-1:0]  queued_ff;
   logic [NUM_HANDLES-1:0]  queued_in;
   link_wr_type             wr_c;
   rsp_type                 res_c;
   logic                    found;
   prio_type                pidx;
   logic                    is_head;
   logic                    is_tail;
   handle_type              h;
   handle_type              t;
   handle_type              p_lnk;
   handle_type              n_lnk;
   logic                    h_valid;

   assign h       = req.handle;
   assign h_valid = (h != '0);
   assign t       = tail_ff[req.prio];

   // Find the first non-empty list, lowest priority number wins
   always_comb begin
      found = 1'b0;
      pidx  = '0;
      for (int q = NUM_PRIORITIES - 1; q >= 0; q--) begin
         if (head_ff[q] != '0) begin
            found = 1'b1;
            pidx  = PRIO_W'(q);
         end
      end
   end

   // Check whether the handle ends a list; its stale links are then ignored
   always_comb begin
      is_head = 1'b0;
      is_tail = 1'b0;
      for (int q = 0; q < NUM_PRIORITIES; q++) begin
         if (head_ff[q] == h) is_head = 1'b1;
         if (tail_ff[q] == h) is_tail = 1'b1;
      end
   end

   assign p_lnk = is_head ? '0 : prev_rd;
   assign n_lnk = is_tail ? '0 : next_rd;

   // Execute one command against the list state
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      queued_in = queued_ff;
      wr_c      = '0;
      res_c     = '0;
      case (cmd_type'(req.cmd))
         CMD_CLEAR: begin
            for (int q = 0; q < NUM_PRIORITIES; q++) begin
               head_in[q] = '0;
               tail_in[q] = '0;
            end
            queued_in = '0;
            res_c.ok  = 1'b1;
         end
         CMD_PUSH: begin
            if (h_valid && !queued_ff[h]) begin
               wr_c.prev_we   = 1'b1;
               wr_c.prev_addr = h;
               wr_c.prev_data = t;
               if (t != '0) begin
                  wr_c.next_we   = 1'b1;
                  wr_c.next_addr = t;
                  wr_c.next_data = h;
               end else begin
                  head_in[req.prio] = h;
               end
               tail_in[req.prio] = h;
               queued_in[h]      = 1'b1;
               res_c.ok          = 1'b1;
            end
         end
         CMD_POP: begin
            if (found) begin
               if (tail_ff[pidx] == head_ff[pidx]) begin
                  head_in[pidx] = '0;
                  tail_in[pidx] = '0;
               end else begin
                  head_in[pidx] = next_rd;
               end
               queued_in[head_ff[pidx]] = 1'b0;
               res_c.ok                 = 1'b1;
               res_c.popped             = head_ff[pidx];
            end
         end
         CMD_REMOVE: begin
            if (h_valid && queued_ff[h]) begin
               if (p_lnk != '0) begin
                  wr_c.next_we   = 1'b1;
                  wr_c.next_addr = p_lnk;
                  wr_c.next_data = n_lnk;
               end
               if (n_lnk != '0) begin
                  wr_c.prev_we   = 1'b1;
                  wr_c.prev_addr = n_lnk;
                  wr_c.prev_data = p_lnk;
               end
               for (int q = 0; q < NUM_PRIORITIES; q++) begin
                  if (head_ff[q] == h) head_in[q] = n_lnk;
                  if (tail_ff[q] == h) tail_in[q] = p_lnk;
               end
               queued_in[h] = 1'b0;
               res_c.ok     = 1'b1;
            end
         end
         CMD_QUERY: begin
            res_c.ok = h_valid && queued_ff[h];
         end
         default: begin
            res_c.ok = 1'b0;
         end
      endcase
      for (int q = 0; q < NUM_PRIORITIES; q++) begin
         if (head_in[q] != '0) res_c.any = 1'b1;
      end
   end

   // Head of the first non-empty list once any executing command has taken effect
   always_comb begin
      pop_head_nxt = '0;
      for (int q = NUM_PRIORITIES - 1; q >= 0; q--) begin
         if (exec) begin
            if (head_in[q] != '0) pop_head_nxt = head_in[q];
         end else begin
            if (head_ff[q] != '0) pop_head_nxt = head_ff[q];
         end
      end
   end

   assign link_wr = exec ? wr_c : '0;
   assign result  = res_c;

   // Hold list state; advance only when the command executes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_PRIORITIES; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
         end
         queued_ff <= '0;
      end else if (exec) begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         queued_ff <= queued_in;
      end
   end

endmodule

FILE: src/multi_priority_linked_wait_queue_core.sv
// Priority wait queue: four FIFO lists of request handles (0 means none), threaded as
// doubly linked lists through two 64-entry link tables. Commands are clear, push to a
// priority, pop from the lowest-numbered non-empty priority, remove a handle and query
// a handle; each gives one result beat with ok, the popped handle and whether any list
// still holds a handle. One command is taken every cycle while the result side keeps
// up. The accepting edge registers the command together with the link-table reads, and
// the edge on which the command stage executes, once the result register is free, runs
// the list update into the result register. A result beat that is not taken
// holds the command stage, so at most one further command is accepted behind it.
// Pushing a handle that is already queued, or removing one that is not, reports failure.
module multi_priority_linked_wait_queue_core
   import mwq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd[2:0], priority_req[4:3], handle[10:5], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // ok[0], popped_handle[6:1], any_waiting[7]
);

   logic        s_vld_ff;
   req_type     req_ff;
   logic        rsp_vld_ff;
   rsp_type     rsp_ff;
   logic        exec;
   logic        accept;
   req_type     req_in;
   handle_type  next_raddr;
   handle_type  next_rd;
   handle_type  prev_rd;
   handle_type  pop_head_nxt;
   link_wr_type link_wr;
   rsp_type     result;

   assign req_in     = req_type'(req_tdata[$bits(req_type)-1:0]);
   assign exec       = s_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s_vld_ff || exec;
   assign accept     = req_tvalid && req_tready;

   // Pop reads the link of the head it will take; other commands read the given handle
   assign next_raddr = (cmd_type'(req_in.cmd) == CMD_POP) ? pop_head_nxt : req_in.handle;

   mwq_link_mem u_link_mem (
      .clock      (clock),
      .rd_en      (accept),
      .next_raddr (next_raddr),
      .prev_raddr (req_in.handle),
      .link_wr    (link_wr),
      .next_rd    (next_rd),
      .prev_rd    (prev_rd)
   );

   mwq_list_ctrl u_list_ctrl (
      .clock        (clock),
      .reset        (reset),
      .exec         (exec),
      .req          (req_ff),
      .next_rd      (next_rd),
      .prev_rd      (prev_rd),
      .link_wr      (link_wr),
      .result       (result),
      .pop_head_nxt (pop_head_nxt)
   );

   // Command stage: hold the beat until its result can be registered
   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (accept) begin
         s_vld_ff <= 1'b1;
      end else if (exec) begin
         s_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   // Result register: load on execute, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (exec) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_ff;

   // A popped handle is only ever reported with success
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.popped == '0 || rsp_ff.ok))
      else $error("popped handle reported without success");

   // A waiting command is never lost while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      (s_vld_ff && rsp_vld_ff && !rsp_tready) |=> s_vld_ff)
      else $error("command dropped during output stall");

   // A clear leaves every list empty
   assert property (@(posedge clock) disable iff (reset)
      (exec && cmd_type'(req_ff.cmd) == CMD_CLEAR) |=> (rsp_ff.ok && !rsp_ff.any))
      else $error("clear left a list non-empty");

endmodule
